// File: src/abst_pkg.sv
// Shared types and constants for the array binary search tree block.
// Used by abst_ctrl, abst_datapath and array_binary_search_tree; no dependencies.
`default_nettype none

package abst_pkg;

	// Default values of the top-level parameters.
	localparam int LEVELS_DEF    = 7;
	localparam int KEY_WIDTH_DEF = 32;

	// The widths of the item fields are fixed.
	localparam int KEY_PORT_W = 32;
	localparam int SLOT_W     = 7;

	// Operation codes on the cmd field.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FIND   = 1'b1;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DUP  = 2'd1,
		ST_FULL = 2'd2,
		ST_ZERO = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clear;        // write zero at the sweep counter and step it
		logic    load_item;    // capture cmd and key, start the read of the root
		logic    advance;      // step to the child slot and read it
		logic    write_key;    // write the held key into the current slot
		logic    res_load;     // capture the outcome of the operation
		status_t res_status;
		logic    res_found;
		logic    res_use_slot; // outcome slot is the current slot, else zero
		logic    out_load;     // move the outcome into the output register
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last; // sweep counter is on the last entry
		logic key_zero; // key at the input port is zero
		logic is_find;  // held operation is a find
		logic hit;      // current slot holds the key
		logic empty;    // current slot is empty
		logic last;     // current slot is on the deepest level
	} dp_stat_t;

endpackage

`default_nettype wire

// File: src/array_binary_search_tree.sv
// Top level of the array binary search tree block: controller plus datapath.
// Depends on abst_pkg, abst_ctrl and abst_datapath.
`default_nettype none

// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------
// input    | in_valid / in_ready        | cmd (1), key (32)
// output   | out_valid / out_ready      | status (2), found (1), slot (7)
//
// The accepting cycle of an insert or find starts the read of the root. Each
// walk step, one per level at most, compares the registered read data with
// the held key and, if the walk goes on, reads the child slot; the done state
// then moves the outcome into the output register. The next item is taken
// only once the block is back in idle. A zero key skips the walk: its outcome
// is captured in the accepting cycle and moved out from the done state.
// After reset all 2**LEVELS entries of the node store are cleared, one entry
// per cycle, and no item is accepted during that pass.
// A held result stalls only the finishing cycle of the next item.

module array_binary_search_tree import abst_pkg::*; #(
	parameter int LEVELS    = LEVELS_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  cmd,
	input  wire logic [KEY_PORT_W-1:0] key,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [1:0]                 status,
	output logic                       found,
	output logic [SLOT_W-1:0]          slot
);

	// Commands go from the controller to the datapath; status comes back.
	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// The controller sequences the clearing pass, the walk and the output
	// handshake. It holds the only control state besides the sweep counter.
	abst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.ctl       (ctl)
	);

	// The datapath owns the node store (one read and one write port with a
	// registered read), the walk position, the key compare and the outcome
	// and output registers.
	abst_datapath #(
		.LEVELS    (LEVELS),
		.KEY_WIDTH (KEY_WIDTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.stat   (stat),
		.cmd    (cmd),
		.key    (key),
		.status (status),
		.found  (found),
		.slot   (slot)
	);

endmodule

`default_nettype wire

// File: src/abst_ctrl.sv
// Controller state machine of the array binary search tree block.
// Depends on abst_pkg; drives abst_datapath through ctrl_cmd_t.
`default_nettype none

module abst_ctrl import abst_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire dp_stat_t  stat,
	output ctrl_cmd_t      ctl
);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_WALK  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctl      = '0;
		ctl.res_status = ST_OK;
		unique case (state_q)
			S_CLEAR: begin
				ctl.clear = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load_item = 1'b1;
					if (stat.key_zero) begin
						ctl.res_load   = 1'b1;
						ctl.res_status = ST_ZERO;
						state_d        = S_DONE;
					end else begin
						state_d = S_WALK;
					end
				end
			end
			S_WALK: begin
				priority if (stat.empty) begin
					// An insert fills the first empty slot; a find misses here.
					ctl.res_load     = 1'b1;
					ctl.res_status   = ST_OK;
					ctl.write_key    = !stat.is_find;
					ctl.res_use_slot = !stat.is_find;
					state_d          = S_DONE;
				end else if (stat.hit) begin
					ctl.res_load     = 1'b1;
					ctl.res_status   = stat.is_find ? ST_OK : ST_DUP;
					ctl.res_found    = stat.is_find;
					ctl.res_use_slot = stat.is_find;
					state_d          = S_DONE;
				end else if (stat.last) begin
					// The walk would leave the store.
					ctl.res_load   = 1'b1;
					ctl.res_status = stat.is_find ? ST_OK : ST_FULL;
					state_d        = S_DONE;
				end else begin
					ctl.advance = 1'b1;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	// A new result never overwrites one that has not been taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	// Only an insert that reaches an empty slot writes the store.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.write_key |-> (stat.empty && !stat.is_find))
		else $error("store written outside an insert into an empty slot");

	// No item is taken while the store is being cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |-> !(in_ready && in_valid))
		else $error("item accepted during the clearing pass");
`endif

endmodule

`default_nettype wire

// File: src/abst_datapath.sv
// Datapath of the array binary search tree block: node store, walk position,
// key compare and result registers. Depends on abst_pkg; driven by abst_ctrl.
`default_nettype none

module abst_datapath import abst_pkg::*; #(
	parameter int LEVELS    = LEVELS_DEF,
	parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ctrl_cmd_t             ctl,
	output dp_stat_t                   stat,
	input  wire logic                  cmd,
	input  wire logic [KEY_PORT_W-1:0] key,
	output logic [1:0]                 status,
	output logic                       found,
	output logic [SLOT_W-1:0]          slot
);

	localparam int SlotCount = 2 ** LEVELS;

	logic [KEY_WIDTH-1:0] mem [SlotCount];
	logic [KEY_WIDTH-1:0] rdata_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [KEY_WIDTH-1:0] key_in;
	logic [KEY_WIDTH-1:0] wr_data;
	logic                 wr_en;
	logic [LEVELS-1:0]    wr_addr;
	logic [LEVELS-1:0]    rd_addr;
	logic [LEVELS-1:0]    pos_q;
	logic [LEVELS-1:0]    next_pos;
	logic [LEVELS-1:0]    clr_cnt_q;
	logic                 is_find_q;
	logic                 key_lt;

	status_t              res_status_q;
	logic                 res_found_q;
	logic [LEVELS-1:0]    res_slot_q;
	status_t              out_status_q;
	logic                 out_found_q;
	logic [LEVELS-1:0]    out_slot_q;

	assign key_in   = KEY_WIDTH'(key);
	assign key_lt   = key_q < rdata_q;
	// Left child is 2i, right child is 2i+1.
	assign next_pos = {pos_q[LEVELS-2:0], ~key_lt};

	assign wr_en   = ctl.clear | ctl.write_key;
	assign wr_addr = ctl.clear ? clr_cnt_q : pos_q;
	assign wr_data = ctl.clear ? '0 : key_q;
	assign rd_addr = ctl.load_item ? LEVELS'(1) : next_pos;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clear) begin
			clr_cnt_q <= clr_cnt_q + LEVELS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			key_q     <= key_in;
			is_find_q <= (cmd == CMD_FIND);
			pos_q     <= LEVELS'(1);
		end else if (ctl.advance) begin
			pos_q <= next_pos;
		end
		if (ctl.res_load) begin
			res_status_q <= ctl.res_status;
			res_found_q  <= ctl.res_found;
			res_slot_q   <= ctl.res_use_slot ? pos_q : '0;
		end
		if (ctl.out_load) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_slot_q   <= res_slot_q;
		end
	end

	assign stat.clr_last = &clr_cnt_q;
	assign stat.key_zero = (key_in == '0);
	assign stat.is_find  = is_find_q;
	assign stat.hit      = (rdata_q == key_q);
	assign stat.empty    = (rdata_q == '0);
	assign stat.last     = pos_q[LEVELS-1];

	assign status = out_status_q;
	assign found  = out_found_q;
	assign slot   = SLOT_W'(out_slot_q);

`ifndef SYNTHESIS
	// The walk never steps past the deepest level of the store.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.advance |-> !pos_q[LEVELS-1])
		else $error("walk stepped beyond the store");

	// Every walk starts at the root.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_item |=> (pos_q == LEVELS'(1)))
		else $error("walk did not start at the root");

	// A key is never written into the unused slot zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		ctl.write_key |-> (pos_q != '0))
		else $error("key written into slot zero");
`endif

endmodule

`default_nettype wire
